### rtl/core/lkst_pkg.sv
// ----------------------------------------------------------------------------
// lkst_pkg
// Shared types and constants for the keyed statistics table.
// ----------------------------------------------------------------------------
package lkst_pkg;

   localparam int unsigned FUNC_W = 3;
   localparam int unsigned SEL_W  = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOOKUP = 3'd0,
      FUNC_SHARE  = 3'd1,
      FUNC_HASHES = 3'd2,
      FUNC_BLOCK  = 3'd3,
      FUNC_READ   = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EMPTY,
      ST_MIN,
      ST_ALLOC,
      ST_REC,
      ST_RESP
   } state_type;

endpackage

### rtl/core/lru_keyed_statistics_table.sv
// ----------------------------------------------------------------------------
// lru_keyed_statistics_table
// Fully associative statistics table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One transaction at a time. A lookup walks the slots with a single key/stamp
// comparator: a match scan, then an empty-slot scan if no slot matches, then
// a minimum-stamp scan if the table is full, then an update state and a
// response state. Record and read transactions go through a record state and
// the response state. The input side is ready only while idle and the result
// register is empty, so the next transaction is accepted in the cycle after
// the result is taken at the earliest.
module lru_keyed_statistics_table #(
   parameter int unsigned SLOTS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // func[2:0], host_key[66:3], port[82:67], slot_sel[85:83],
   // share_diff_bits[148:86], hash_count[212:149], now_ts[245:213]
   input  logic [247:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // slot_index[2:0], was_hit[3], was_evicted[4], share_total[36:5],
   // hash_total[100:37], best_bits[163:101], best_time[196:164],
   // block_total[228:197], block_time[261:229], life_blocks[293:262],
   // life_block_time[326:294], slot_in_use[327]
   output logic [327:0]  rsp_tdata
);
   import lkst_pkg::*;

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);

   logic [63:0] key_ff  [SLOTS];
   logic [15:0] port_ff [SLOTS];
   logic [63:0] stamp_ff[SLOTS];
   logic [31:0] shr_ff  [SLOTS];
   logic [63:0] hsh_ff  [SLOTS];
   logic [62:0] best_ff [SLOTS];
   logic [32:0] btm_ff  [SLOTS];
   logic [31:0] blk_ff  [SLOTS];
   logic [32:0] blkt_ff [SLOTS];
   logic [31:0] life_cnt_ff;
   logic [32:0] life_ts_ff;
   logic [63:0] clk_ff;

   state_type   state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic [63:0] min_ff, min_in;
   logic        hit_ff, hit_in, evi_ff, evi_in;
   logic [247:0] req_ff;
   logic        rv_ff, rv_in;
   logic [327:0] rsp_ff, rsp_in;

   logic [2:0]  r_func, r_sel;
   logic [63:0] r_key, r_hash;
   logic [15:0] r_port;
   logic [62:0] r_diff;
   logic [32:0] r_now;
   assign r_func = req_ff[2:0];
   assign r_key  = req_ff[66:3];
   assign r_port = req_ff[82:67];
   assign r_sel  = req_ff[85:83];
   assign r_diff = req_ff[148:86];
   assign r_hash = req_ff[212:149];
   assign r_now  = req_ff[245:213];

   logic [IW-1:0] cur;
   logic          at_end, match, sel_ok;
   logic [IW-1:0] sel_idx;
   assign cur     = idx_ff[IW-1:0];
   assign at_end  = (idx_ff == CW'(SLOTS - 1));
   assign match   = (stamp_ff[cur] != 64'd0) && (key_ff[cur] == r_key)
                    && (port_ff[cur] == r_port);
   assign sel_ok  = ({{(32-SEL_W){1'b0}}, r_sel} < 32'(SLOTS));
   assign sel_idx = IW'(r_sel);

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      tgt_in = tgt_ff;
      min_in = min_ff;
      hit_in = hit_ff;
      evi_in = evi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               idx_in = '0;
               hit_in = 1'b0;
               evi_in = 1'b0;
               if (req_tdata[2:0] == FUNC_LOOKUP) state_in = ST_MATCH;
               else state_in = ST_REC;
            end
         end
         ST_MATCH: begin
            if (match) begin
               hit_in = 1'b1;
               tgt_in = cur;
               state_in = ST_ALLOC;
            end else if (at_end) begin
               idx_in = '0;
               state_in = ST_EMPTY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMPTY: begin
            if (stamp_ff[cur] == 64'd0) begin
               tgt_in = cur;
               state_in = ST_ALLOC;
            end else if (at_end) begin
               tgt_in = '0;
               min_in = stamp_ff[0];
               idx_in = CW'(1);
               evi_in = 1'b1;
               state_in = ST_MIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MIN: begin
            if (stamp_ff[cur] < min_ff) begin
               tgt_in = cur;
               min_in = stamp_ff[cur];
            end
            if (at_end) state_in = ST_ALLOC;
            else idx_in = idx_ff + 1'b1;
         end
         ST_ALLOC: state_in = ST_RESP;
         ST_REC:   state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rv_in = (state_ff == ST_RESP) ? 1'b1 : (rv_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         clk_ff <= 64'd1;
         life_cnt_ff <= '0;
         life_ts_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            key_ff[i] <= '0; port_ff[i] <= '0; stamp_ff[i] <= '0;
            shr_ff[i] <= '0; hsh_ff[i] <= '0; best_ff[i] <= '0;
            btm_ff[i] <= '0; blk_ff[i] <= '0; blkt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (state_ff == ST_ALLOC) begin
            stamp_ff[tgt_ff] <= clk_ff;
            clk_ff <= clk_ff + 64'd1;
            if (!hit_ff) begin
               key_ff[tgt_ff] <= r_key; port_ff[tgt_ff] <= r_port;
               shr_ff[tgt_ff] <= '0; hsh_ff[tgt_ff] <= '0; best_ff[tgt_ff] <= '0;
               btm_ff[tgt_ff] <= '0; blk_ff[tgt_ff] <= '0; blkt_ff[tgt_ff] <= '0;
            end
         end
         if (state_ff == ST_REC && sel_ok) begin
            unique case (r_func)
               FUNC_SHARE: begin
                  shr_ff[sel_idx] <= shr_ff[sel_idx] + 32'd1;
                  if (r_diff > best_ff[sel_idx]) begin
                     best_ff[sel_idx] <= r_diff;
                     btm_ff[sel_idx] <= r_now;
                  end
               end
               FUNC_HASHES: hsh_ff[sel_idx] <= hsh_ff[sel_idx] + r_hash;
               FUNC_BLOCK: begin
                  blk_ff[sel_idx] <= blk_ff[sel_idx] + 32'd1;
                  blkt_ff[sel_idx] <= r_now;
                  life_cnt_ff <= life_cnt_ff + 32'd1;
                  life_ts_ff <= r_now;
               end
               default: ;
            endcase
         end
      end
   end

   logic          rd_ok;
   logic [IW-1:0] rd_idx;
   assign rd_ok  = (r_func == FUNC_LOOKUP) || sel_ok;
   assign rd_idx = (r_func == FUNC_LOOKUP) ? tgt_ff : sel_idx;

   always_comb begin
      rsp_in = '0;
      rsp_in[2:0] = (r_func == FUNC_LOOKUP) ? 3'(tgt_ff) : r_sel;
      rsp_in[3] = hit_ff;
      rsp_in[4] = evi_ff && !hit_ff;
      if (rd_ok) begin
         rsp_in[36:5]    = shr_ff[rd_idx];
         rsp_in[100:37]  = hsh_ff[rd_idx];
         rsp_in[163:101] = best_ff[rd_idx];
         rsp_in[196:164] = btm_ff[rd_idx];
         rsp_in[228:197] = blk_ff[rd_idx];
         rsp_in[261:229] = blkt_ff[rd_idx];
         rsp_in[327]     = (stamp_ff[rd_idx] != 64'd0);
      end
      rsp_in[293:262] = life_cnt_ff;
      rsp_in[326:294] = life_ts_ff;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      min_ff <= min_in;
      hit_ff <= hit_in;
      evi_ff <= evi_in;
      if (req_tvalid && req_tready) req_ff <= req_tdata;
      if (state_ff == ST_RESP) rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE)) else $error("ready outside idle");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> rsp_tvalid) else $error("response lost");
   a_clock_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |=> (clk_ff == $past(clk_ff) + 64'd1))
      else $error("access clock not advanced");
`endif

endmodule
